// ===== hw/rtl/sdt_pkg.sv =====
// Shared types and constants of the one-dimensional squared-distance transform.
// Used by sdt_div and squared_distance_transform_1d; depends on nothing.
`default_nettype none
package sdt_pkg;
  localparam int LENGTH   = 1024;
  localparam int ADDR_W   = 10;
  localparam int CNT_W    = 11;
  localparam int SAMPLE_W = 24;
  localparam int FRAC_W   = 8;
  localparam int BND_W    = SAMPLE_W + FRAC_W + 2;
  localparam int DEN_W    = ADDR_W + 1;
  localparam int DIST_W   = 25;

  // Command codes carried in tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // Request to the serial divider: signed numerator as sign and magnitude.
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [BND_W-1:0]  mag;
    logic [DEN_W-1:0]  den;
  } div_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sdt_div.sv =====
// Bit-serial restoring divider, floor rounding for negative numerators.
// Depends on sdt_pkg.
`default_nettype none
module sdt_div (
  input  wire                            clk,
  input  wire                            rst_n,
  input  sdt_pkg::div_req_t              req,
  output logic                           done,
  output logic signed [sdt_pkg::BND_W-1:0] quot
);
  import sdt_pkg::*;

  localparam int CW = $clog2(BND_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [BND_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic [BND_W-1:0] mag_up;

  // One quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_r, quo_r[BND_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(BND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.mag;
      rem_r <= '0;
      den_r <= req.den;
      neg_r <= req.neg;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[BND_W-2:0], ge};
    end
  end

  // A negative quotient rounds toward minus infinity.
  always_comb begin
    mag_up = quo_r + BND_W'(rem_r != '0);
    quot   = neg_r ? -$signed(mag_up) : $signed(quo_r);
  end

  assign done = done_r;
endmodule
`default_nettype wire

// ===== hw/rtl/squared_distance_transform_1d.sv =====
// Top level of the squared-distance transform: stream ports, sequencer, line memories.
// Depends on sdt_pkg and sdt_div.
//
// A load request (tuser 0) stores one sample; the sample with tlast
// set starts the envelope build, during which in_tready is low. The build reads
// each sample in turn and then runs one intersection per candidate vertex through
// the serial divider, one intersection per sample plus one per stack pop. A fetch
// request (tuser 1) steps over envelope segments; the result is held in an output
// register while the next request may already enter. A fetch with no line ready
// returns tuser 1 and zero data.
`default_nettype none
module squared_distance_transform_1d (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // [23:0] sample
  input  wire         in_tuser,   // [0] cmd
  input  wire         in_tlast,   // last_in
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [24:0] distance, [31:25] zero
  output logic        out_tuser,  // [0] empty_res
  output logic        out_tlast   // last_out
);
  import sdt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDQ  = 4'd1;
  localparam logic [3:0] S_FQ   = 4'd2;
  localparam logic [3:0] S_RDT  = 4'd3;
  localparam logic [3:0] S_TOP  = 4'd4;
  localparam logic [3:0] S_NUM  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_SCAN = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_VTX  = 4'd10;
  localparam logic [3:0] S_VC   = 4'd11;
  localparam logic [3:0] S_SQ   = 4'd12;
  localparam logic [3:0] S_ADD  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0]  state_r, state_nxt;

  // Line memories.
  logic [SAMPLE_W-1:0]     cost_mem [LENGTH];
  logic [ADDR_W-1:0]       vert_mem [LENGTH];
  logic signed [BND_W-1:0] bnd_mem  [LENGTH];

  logic [SAMPLE_W-1:0]     cost_rd;
  logic [ADDR_W-1:0]       vert_rd;
  logic signed [BND_W-1:0] bnd_rd;
  logic [ADDR_W-1:0]       cost_raddr, vert_raddr, bnd_raddr;
  logic                    cost_we;
  logic [ADDR_W-1:0]       cost_waddr;
  logic                    env_we;
  logic                    start_build;
  logic                    vert_we;
  logic [ADDR_W-1:0]       vert_waddr;
  logic [ADDR_W-1:0]       vert_wdata;

  // Control registers.
  logic [ADDR_W-1:0] top_r;
  logic [CNT_W-1:0]  lc_r;
  logic [CNT_W-1:0]  rp_r;
  logic [ADDR_W-1:0] ep_r;
  logic              rr_r;

  // Build working registers.
  logic [CNT_W-1:0]        q_r;
  logic [SAMPLE_W-1:0]     fq_r;
  logic [ADDR_W-1:0]       u_r;
  logic signed [BND_W-1:0] btop_r;
  logic [2*ADDR_W-1:0]     qsq_r, usq_r;

  // Fetch working registers.
  logic [ADDR_W-1:0]   v_r;
  logic [SAMPLE_W-1:0] cv_r;
  logic [2*CNT_W-1:0]  dsq_r;

  // Result register.
  logic              ov_r;
  logic [DIST_W-1:0] res_dist_r;
  logic              res_last_r, res_empty_r;

  div_req_t                div_req;
  logic                    div_done;
  logic signed [BND_W-1:0] div_q;

  logic                    acc;
  logic [CNT_W-1:0]        lc_eff;
  logic signed [BND_W-1:0] qfx;
  logic [CNT_W-1:0]        delta;
  logic                    pop;
  logic                    out_free;

  sdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign lc_eff    = rr_r ? '0 : lc_r;
  assign out_free  = !ov_r || out_tready;

  // Intersection numerator (f[q] - f[u] + q*q - u*u), exact.
  localparam int NW = SAMPLE_W + 3;
  logic signed [NW-1:0] num;
  logic [NW-1:0]        num_mag;
  always_comb begin
    num = $signed({3'b000, fq_r}) - $signed({3'b000, cost_rd})
        + $signed(NW'(qsq_r)) - $signed(NW'(usq_r));
    num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    div_req.start = (state_r == S_NUM);
    div_req.neg   = num[NW-1];
    div_req.mag   = BND_W'({num_mag, {FRAC_W{1'b0}}});
    div_req.den   = {q_r[ADDR_W-1:0] - u_r, 1'b0};
  end

  // Readout position in boundary format.
  assign qfx = $signed(BND_W'({rp_r, {FRAC_W{1'b0}}}));
  assign pop = (top_r != '0) && (div_q <= btop_r);
  assign delta = (rp_r >= CNT_W'(v_r)) ? CNT_W'(rp_r - CNT_W'(v_r))
                                       : CNT_W'(CNT_W'(v_r) - rp_r);

  // Memory addresses by state.
  always_comb begin
    cost_raddr = q_r[ADDR_W-1:0];
    vert_raddr = top_r;
    bnd_raddr  = top_r;
    unique case (state_r)
      S_TOP:   cost_raddr = vert_rd;
      S_VC:    cost_raddr = vert_rd;
      S_SCAN:  bnd_raddr  = ep_r + 1'b1;
      S_VTX:   vert_raddr = ep_r;
      default: ;
    endcase
    cost_we     = acc && (in_tuser == CMD_LOAD) && (lc_eff < CNT_W'(LENGTH));
    cost_waddr  = lc_eff[ADDR_W-1:0];
    env_we      = (state_r == S_CMP) && !pop;
    // The stack bottom holds vertex zero from the start of every build.
    start_build = acc && (in_tuser == CMD_LOAD) && in_tlast;
    vert_we     = env_we || start_build;
    vert_waddr  = env_we ? ADDR_W'(top_r + 1'b1) : '0;
    vert_wdata  = env_we ? q_r[ADDR_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_waddr] <= in_tdata[SAMPLE_W-1:0];
    cost_rd <= cost_mem[cost_raddr];
  end

  always_ff @(posedge clk) begin
    if (vert_we) vert_mem[vert_waddr] <= vert_wdata;
    vert_rd <= vert_mem[vert_raddr];
  end

  always_ff @(posedge clk) begin
    if (env_we) bnd_mem[top_r + 1'b1] <= div_q;
    bnd_rd <= bnd_mem[bnd_raddr];
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_tuser == CMD_LOAD) begin
            if (in_tlast) state_nxt = S_RDQ;
          end else if (rr_r) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RDQ:  state_nxt = (q_r >= lc_r) ? S_IDLE : S_FQ;
      S_FQ:   state_nxt = S_RDT;
      S_RDT:  state_nxt = S_TOP;
      S_TOP:  state_nxt = S_NUM;
      S_NUM:  state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_CMP;
      S_CMP:  state_nxt = pop ? S_RDT : S_RDQ;
      S_SCAN: state_nxt = (ep_r < top_r) ? S_CHK : S_VTX;
      S_CHK:  state_nxt = (bnd_rd < qfx) ? S_SCAN : S_VTX;
      S_VTX:  state_nxt = S_VC;
      S_VC:   state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ADD;
      S_ADD:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r   <= '0;
      lc_r    <= '0;
      rp_r    <= '0;
      ep_r    <= '0;
      rr_r    <= 1'b0;
      q_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Output slot: filled from S_OUT, emptied by the consumer.
      if ((state_r == S_OUT) && out_free) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc && (in_tuser == CMD_LOAD)) begin
            rr_r <= 1'b0;
            rp_r <= '0;
            ep_r <= '0;
            lc_r <= (lc_eff < CNT_W'(LENGTH)) ? lc_eff + 1'b1 : lc_eff;
            if (in_tlast) begin
              top_r <= '0;
              q_r   <= CNT_W'(1);
            end
          end
        end
        S_RDQ: begin
          if (q_r >= lc_r) rr_r <= 1'b1;
        end
        S_CMP: begin
          if (pop) begin
            top_r <= top_r - 1'b1;
          end else begin
            top_r <= top_r + 1'b1;
            q_r   <= q_r + 1'b1;
          end
        end
        S_CHK: begin
          if (bnd_rd < qfx) ep_r <= ep_r + 1'b1;
        end
        S_ADD: begin
          if (rp_r + 1'b1 >= lc_r) begin
            rr_r <= 1'b0;
            lc_r <= '0;
            rp_r <= '0;
            ep_r <= '0;
          end else begin
            rp_r <= rp_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        res_dist_r  <= '0;
        res_last_r  <= 1'b0;
        res_empty_r <= 1'b1;
      end
      S_FQ:  begin
        fq_r  <= cost_rd;
        qsq_r <= q_r[ADDR_W-1:0] * q_r[ADDR_W-1:0];
      end
      S_TOP: begin
        u_r    <= vert_rd;
        btop_r <= bnd_rd;
        usq_r  <= vert_rd * vert_rd;
      end
      S_VC:  v_r <= vert_rd;
      S_SQ: begin
        cv_r  <= cost_rd;
        dsq_r <= delta * delta;
      end
      S_ADD: begin
        res_dist_r  <= DIST_W'(dsq_r) + DIST_W'(cv_r);
        res_last_r  <= (rp_r + 1'b1 >= lc_r);
        res_empty_r <= 1'b0;
      end
      default: ;
    endcase
  end

  // Output register, loaded when the slot is free.
  logic [DIST_W-1:0] od_r;
  logic              ol_r, oe_r;
  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      od_r <= res_dist_r;
      ol_r <= res_last_r;
      oe_r <= res_empty_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(32-DIST_W){1'b0}}, od_r};
  assign out_tuser  = oe_r;
  assign out_tlast  = ol_r;

`ifndef SYNTH
  // An empty answer carries no distance and never ends a line.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0) && !out_tlast)
    else $error("empty result carries data");

  // The stack never grows past the sample being placed.
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (top_r < q_r))
    else $error("stack top beyond current sample");

  // The readout pointer stays inside the envelope.
  a_ep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rr_r |-> (ep_r <= top_r))
    else $error("envelope pointer beyond stack top");

  // The divider finishes only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider result not awaited");
`endif
endmodule
`default_nettype wire
